[sv/ocp_pkg.sv]
// shared types and command codes of the oled controller command parser
package ocp_pkg;

    // frame store geometry
    localparam int unsigned COLUMNS = 128;
    localparam int unsigned PAGES   = 8;

    // bus event kinds carried in the slave tuser
    localparam logic [1:0] EV_ADDRESS = 2'd0;
    localparam logic [1:0] EV_WRITE   = 2'd1;
    localparam logic [1:0] EV_READ    = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_RESPOND_ENABLE = 1'b1;

    // command codes and masks
    localparam logic [7:0] CMD_PAGE_MASK   = 8'hF8;
    localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
    localparam logic [7:0] CMD_CONTRAST    = 8'h81;
    localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
    localparam logic [7:0] CMD_COL_RANGE   = 8'h21;
    localparam logic [7:0] CMD_PAGE_RANGE  = 8'h22;
    localparam logic [7:0] CMD_CLOCK_DIV   = 8'hD5;
    localparam logic [7:0] CMD_MUX_RATIO   = 8'hA8;
    localparam logic [7:0] CMD_DISP_OFFSET = 8'hD3;
    localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
    localparam logic [7:0] CMD_COM_PINS    = 8'hDA;
    localparam logic [7:0] CMD_PRECHARGE   = 8'hD9;
    localparam logic [7:0] CMD_VCOM_LEVEL  = 8'hDB;

    // control byte bit that selects data transfers
    localparam int unsigned CTRL_DATA_BIT = 6;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [7:0] column_now;
        logic [2:0] page_now;
        logic [1:0] addressing_mode;
        logic [7:0] contrast;
        logic       panel_on;
        logic [7:0] mem_data;
        logic [9:0] mem_index;
        logic       mem_write;
        logic [7:0] read_data;
        logic       ack;
    } t_result;

endpackage

[sv/oled_controller_command_parser.sv]
// oled controller command parser: bus event decode, command state and result register
// the result reaches the master side in the cycle after its input transaction is accepted
// one input transaction per cycle while s_axis_tready is high, decode sits between input and result register
// s_axis_tready stays high while the result register is empty or being drained
// synchronous active-low reset: parser armed for a control byte, pointers and mode zero,
// display off, brightness 255, device address 60 with responding enabled
module oled_controller_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input events
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // address[6:0], data_byte[14:7], zero fill
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // ack, read_data, mem_write, mem_index, mem_data,
                                       // panel_on, contrast, addressing_mode, page_now,
                                       // column_now, zero fill
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import ocp_pkg::*;

    localparam int unsigned COL_W = $clog2(COLUMNS);
    localparam int unsigned IDX_W = $clog2(COLUMNS * PAGES);

    // configuration registers
    logic [6:0] r_device_address;
    logic       r_respond_enable;

    // parser state
    logic       r_expect_control, n_expect_control;
    logic       r_data_phase,     n_data_phase;
    logic [7:0] r_pending,        n_pending;
    logic [1:0] r_args_left,      n_args_left;
    logic [7:0] r_column,         n_column;
    logic [2:0] r_page,           n_page;
    logic [1:0] r_addr_mode,      n_addr_mode;
    logic [7:0] r_brightness,     n_brightness;
    logic       r_display_on,     n_display_on;

    // result register
    logic       r_out_valid;
    t_result    r_result, n_result;

    logic       in_accept;
    logic [1:0] in_mode;
    logic [6:0] in_address;
    logic [7:0] in_byte;

    assign in_mode    = s_axis_tuser;
    assign in_address = s_axis_tdata[6:0];
    assign in_byte    = s_axis_tdata[14:7];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_result};

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 7'd60;
            r_respond_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data;
                CFG_RESPOND_ENABLE: r_respond_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // event decode and next state
    always_comb begin
        logic [IDX_W:0] mem_sum;
        logic [1:0]     args_dec;

        n_expect_control = r_expect_control;
        n_data_phase     = r_data_phase;
        n_pending        = r_pending;
        n_args_left      = r_args_left;
        n_column         = r_column;
        n_page           = r_page;
        n_addr_mode      = r_addr_mode;
        n_brightness     = r_brightness;
        n_display_on     = r_display_on;
        n_result         = '0;

        // page times columns plus column, top bit flags beyond the frame store
        mem_sum  = {1'b0, r_page, {COL_W{1'b0}}} + {{(IDX_W - 7){1'b0}}, r_column};
        args_dec = r_args_left - 2'd1;

        case (in_mode)
            EV_ADDRESS: begin
                if (r_respond_enable && in_address == r_device_address) begin
                    n_result.ack     = 1'b1;
                    n_expect_control = 1'b1;
                end
            end
            EV_WRITE: begin
                if (r_expect_control) begin
                    // control byte
                    n_data_phase     = in_byte[CTRL_DATA_BIT];
                    n_expect_control = 1'b0;
                end else if (r_data_phase) begin
                    // display data byte
                    if (!mem_sum[IDX_W]) begin
                        n_result.mem_write = 1'b1;
                        n_result.mem_index = mem_sum[IDX_W-1:0];
                        n_result.mem_data  = in_byte;
                    end
                    if (r_column >= 8'(COLUMNS - 1)) begin
                        n_column = '0;
                        if (r_addr_mode == 2'd0) begin
                            n_page = r_page + 3'd1;
                        end
                    end else begin
                        n_column = r_column + 8'd1;
                    end
                end else if (r_args_left != 2'd0) begin
                    // command argument byte
                    n_args_left = args_dec;
                    if (r_pending == CMD_ADDR_MODE) begin
                        n_addr_mode = in_byte[1:0];
                    end else if (r_pending == CMD_CONTRAST) begin
                        n_brightness = in_byte;
                    end
                    if (args_dec == 2'd0) begin
                        n_pending = '0;
                    end
                end else if ((in_byte & CMD_PAGE_MASK) == CMD_PAGE_BASE) begin
                    n_page = in_byte[2:0];
                end else if (in_byte[7:4] == 4'h0) begin
                    n_column = {r_column[7:4], in_byte[3:0]};
                end else if (in_byte[7:4] == 4'h1) begin
                    n_column = {in_byte[3:0], r_column[3:0]};
                end else if (in_byte[7:6] == 2'b01) begin
                    // start line commands carry no state here
                end else begin
                    case (in_byte) inside
                        CMD_DISPLAY_OFF: n_display_on = 1'b0;
                        CMD_DISPLAY_ON:  n_display_on = 1'b1;
                        CMD_CLOCK_DIV, CMD_MUX_RATIO, CMD_DISP_OFFSET, CMD_CHARGE_PUMP,
                        CMD_ADDR_MODE, CMD_COM_PINS, CMD_CONTRAST, CMD_PRECHARGE,
                        CMD_VCOM_LEVEL: begin
                            n_pending   = in_byte;
                            n_args_left = 2'd1;
                        end
                        CMD_COL_RANGE, CMD_PAGE_RANGE: begin
                            n_pending   = in_byte;
                            n_args_left = 2'd2;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        n_result.panel_on        = n_display_on;
        n_result.contrast        = n_brightness;
        n_result.addressing_mode = n_addr_mode;
        n_result.page_now        = n_page;
        n_result.column_now      = n_column;
    end

    // state update on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_control <= 1'b1;
            r_data_phase     <= 1'b0;
            r_pending        <= '0;
            r_args_left      <= '0;
            r_column         <= '0;
            r_page           <= '0;
            r_addr_mode      <= '0;
            r_brightness     <= 8'd255;
            r_display_on     <= 1'b0;
        end else if (in_accept) begin
            r_expect_control <= n_expect_control;
            r_data_phase     <= n_data_phase;
            r_pending        <= n_pending;
            r_args_left      <= n_args_left;
            r_column         <= n_column;
            r_page           <= n_page;
            r_addr_mode      <= n_addr_mode;
            r_brightness     <= n_brightness;
            r_display_on     <= n_display_on;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

`ifndef SYNTHESIS
    // a pending command exists exactly while arguments are outstanding
    a_pending_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_args_left == 2'd0) |-> (r_pending == 8'd0))
        else $error("pending command left without arguments");

    a_args_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_args_left != 2'd3)
        else $error("argument count out of range");

    // memory write fields are zero when no write happens
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.mem_write) |->
        (r_result.mem_index == '0 && r_result.mem_data == '0))
        else $error("memory fields set without a write");

    // an acknowledge never comes with a memory write
    a_ack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.ack && r_result.mem_write))
        else $error("ack and memory write together");

    // a result accepted into the register shows up as valid next cycle
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction lost");
`endif

endmodule

[tb/sv/tb.sv]
// testbench of the oled controller command parser: directed and random bus events
module tb;
    import ocp_pkg::*;

    // unused bus event kind, treated like a read
    localparam logic [1:0]  EV_UNUSED    = 2'd3;
    localparam logic [7:0]  CTRL_COMMAND = 8'h00;
    localparam logic [7:0]  CTRL_DATA    = 8'h40;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // address[6:0], data_byte[14:7], zero fill
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // ack, read_data, mem_write, mem_index, mem_data, panel_on,
                                 // contrast, addressing_mode, page_now, column_now, zero fill
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;

    // parser state as predicted
    logic        p_expect_ctrl;
    logic        p_data_mode;
    logic [7:0]  p_cmd;
    logic [1:0]  p_args;
    logic [7:0]  p_col;
    logic [2:0]  p_page;
    logic [1:0]  p_amode;
    logic [7:0]  p_bright;
    logic        p_disp;
    logic [6:0]  cfg_addr;
    logic        cfg_enable;

    t_result     expected_results[$];
    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          idle_off;
    bit          hold_request;

    oled_controller_command_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // command byte handling, including argument bytes of multi-byte commands
    function automatic void apply_command(logic [7:0] c);
        if (p_args != 2'd0) begin
            p_args = p_args - 2'd1;
            if (p_cmd == CMD_ADDR_MODE)
                p_amode = c[1:0];
            else if (p_cmd == CMD_CONTRAST)
                p_bright = c;
            if (p_args == 2'd0)
                p_cmd = 8'h00;
        end else if ((c & CMD_PAGE_MASK) == CMD_PAGE_BASE) begin
            p_page = c[2:0];
        end else if (c[7:4] == 4'h0) begin
            p_col = {p_col[7:4], c[3:0]};
        end else if (c[7:4] == 4'h1) begin
            p_col = {c[3:0], p_col[3:0]};
        end else if (c[7:6] == 2'b01) begin
            // start line command byte carries no state and is ignored
        end else begin
            case (c)
                CMD_DISPLAY_OFF: p_disp = 1'b0;
                CMD_DISPLAY_ON:  p_disp = 1'b1;
                CMD_CLOCK_DIV, CMD_MUX_RATIO, CMD_DISP_OFFSET, CMD_CHARGE_PUMP,
                CMD_ADDR_MODE, CMD_COM_PINS, CMD_CONTRAST, CMD_PRECHARGE,
                CMD_VCOM_LEVEL: begin
                    p_cmd  = c;
                    p_args = 2'd1;
                end
                CMD_COL_RANGE, CMD_PAGE_RANGE: begin
                    p_cmd  = c;
                    p_args = 2'd2;
                end
                default: ;
            endcase
        end
    endfunction

    // predicted result of one bus event
    function automatic t_result decode_event(logic [1:0] mode, logic [6:0] addr,
                                             logic [7:0] data);
        t_result     r;
        int unsigned idx;
        r = '0;
        if (mode == EV_ADDRESS) begin
            if (cfg_enable && addr == cfg_addr) begin
                r.ack         = 1'b1;
                p_expect_ctrl = 1'b1;
            end
        end else if (mode == EV_WRITE) begin
            if (p_expect_ctrl) begin
                p_data_mode   = data[CTRL_DATA_BIT];
                p_expect_ctrl = 1'b0;
            end else if (p_data_mode) begin
                idx = p_page * COLUMNS + p_col;
                if (idx < COLUMNS * PAGES) begin
                    r.mem_write = 1'b1;
                    r.mem_index = idx[9:0];
                    r.mem_data  = data;
                end
                if (p_col + 1 > COLUMNS - 1) begin
                    p_col = 8'd0;
                    if (p_amode == 2'd0)
                        p_page = p_page + 3'd1;
                end else begin
                    p_col = p_col + 8'd1;
                end
            end else begin
                apply_command(data);
            end
        end
        r.panel_on        = p_disp;
        r.contrast        = p_bright;
        r.addressing_mode = p_amode;
        r.page_now        = p_page;
        r.column_now      = p_col;
        return r;
    endfunction

    // one field compare
    task automatic compare_field(string name, logic [9:0] want, logic [9:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // result checker
    initial begin
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[49:0]);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result transaction: expected none actual %0h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("ack", 10'(want.ack), 10'(got.ack));
                    compare_field("read_data", 10'(want.read_data), 10'(got.read_data));
                    compare_field("mem_write", 10'(want.mem_write), 10'(got.mem_write));
                    compare_field("mem_index", want.mem_index, got.mem_index);
                    compare_field("mem_data", 10'(want.mem_data), 10'(got.mem_data));
                    compare_field("panel_on", 10'(want.panel_on), 10'(got.panel_on));
                    compare_field("contrast", 10'(want.contrast), 10'(got.contrast));
                    compare_field("addressing_mode", 10'(want.addressing_mode),
                                  10'(got.addressing_mode));
                    compare_field("page_now", 10'(want.page_now), 10'(got.page_now));
                    compare_field("column_now", 10'(want.column_now), 10'(got.column_now));
                end
            end
        end
    end

    // result side ready: random stall bursts and one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!idle_off && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // send one bus event, valid stays high after the transaction
    task automatic send_event(logic [1:0] mode, logic [6:0] addr, logic [7:0] data);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, data, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(decode_event(mode, addr, data));
        items_sent++;
    endtask

    // register write once every result has come back
    task automatic write_register(logic idx, logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_DEVICE_ADDRESS)
            cfg_addr = value;
        else
            cfg_enable = value[0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_write(logic [7:0] data);
        send_event(EV_WRITE, 7'($urandom_range(0, 127)), data);
    endtask

    // random command byte biased toward codes the parser knows
    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0:  c = CMD_PAGE_BASE | {5'd0, c[2:0]};
            1:  c = {4'h0, c[3:0]};
            2:  c = {4'h1, c[3:0]};
            3:  c = c[0] ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF;
            4:  c = CMD_CONTRAST;
            5:  c = CMD_ADDR_MODE;
            6:  c = c[0] ? CMD_COL_RANGE : CMD_PAGE_RANGE;
            7: begin
                case (c[2:0])
                    3'd0:    c = CMD_CLOCK_DIV;
                    3'd1:    c = CMD_MUX_RATIO;
                    3'd2:    c = CMD_DISP_OFFSET;
                    3'd3:    c = CMD_CHARGE_PUMP;
                    3'd4:    c = CMD_COM_PINS;
                    3'd5:    c = CMD_PRECHARGE;
                    default: c = CMD_VCOM_LEVEL;
                endcase
            end
            8:  c = {2'b01, c[5:0]};
            default: ;
        endcase
        return c;
    endfunction

    // one random transfer, mostly well formed, some noise
    task automatic send_random_transfer();
        int unsigned n;
        logic [7:0]  c;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: send_event(EV_READ, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
                1: send_event(EV_UNUSED, 7'($urandom_range(0, 127)),
                              8'($urandom_range(0, 255)));
                default: send_event(EV_ADDRESS, 7'($urandom_range(0, 127)),
                                    8'($urandom_range(0, 255)));
            endcase
            return;
        end
        // address phase, usually ours
        if ($urandom_range(0, 7) == 0)
            send_event(EV_ADDRESS, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        else
            send_event(EV_ADDRESS, cfg_addr, 8'($urandom_range(0, 255)));
        c = 8'($urandom_range(0, 255));
        send_write(c);
        if (c[CTRL_DATA_BIT]) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140)
                                             : $urandom_range(1, 24);
            repeat (n) send_write(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                c = pick_command();
                send_write(c);
                if (c == CMD_CONTRAST || c == CMD_ADDR_MODE || c == CMD_COL_RANGE)
                    send_write(8'($urandom_range(0, 255)));
            end
        end
        // occasional read at the end of a transfer
        if ($urandom_range(0, 5) == 0)
            send_event(EV_READ, cfg_addr, 8'($urandom_range(0, 255)));
    endtask

    // address match, enable gating, reads and the unused event kind
    task automatic test_address_decode();
        write_register(CFG_DEVICE_ADDRESS, 7'd60);
        write_register(CFG_RESPOND_ENABLE, 7'd1);
        send_event(EV_ADDRESS, 7'd60, 8'hFF);
        send_event(EV_ADDRESS, 7'd61, 8'h00);
        send_event(EV_READ, 7'd127, 8'hFF);
        send_event(EV_UNUSED, 7'd0, 8'hFF);
        write_register(CFG_RESPOND_ENABLE, 7'd0);
        send_event(EV_ADDRESS, 7'd60, 8'h00);
        write_register(CFG_RESPOND_ENABLE, 7'd1);
    endtask

    // a set of commands, argument swallowing and start line bytes
    task automatic test_commands();
        send_event(EV_ADDRESS, 7'd60, 8'h00);
        send_write(CTRL_COMMAND);
        send_write(CMD_DISPLAY_ON);
        send_write(CMD_CONTRAST);
        send_write(8'h00);
        send_write(CMD_ADDR_MODE);
        send_write(8'hFF);
        send_write(CMD_COL_RANGE);
        send_write(8'h05);
        send_write(8'h7F);
        send_write(8'h55);
        send_write(8'h5A);
        send_write(CMD_PAGE_BASE | 8'h07);
        send_write(8'h1F);
        send_write(8'h0F);
        // page command pattern taken as an argument
        send_write(CMD_CLOCK_DIV);
        send_write(CMD_PAGE_BASE);
        send_write(CMD_DISPLAY_OFF);
    endtask

    // data beyond the frame store, column wrap, unmatched address keeps the transfer
    task automatic test_data_edges();
        send_event(EV_ADDRESS, 7'd60, 8'h00);
        send_write(8'hC0);
        send_write(8'hFF);
        send_event(EV_ADDRESS, 7'd0, 8'hFF);
        send_write(8'h00);
        send_event(EV_READ, 7'd60, 8'h00);
    endtask

    // long result stall while events keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (20) send_random_transfer();
    endtask

    // random phase under one register setting
    task automatic test_random_phase(int unsigned target, logic [6:0] addr_value,
                                     logic enable_value);
        write_register(CFG_DEVICE_ADDRESS, addr_value);
        write_register(CFG_RESPOND_ENABLE, {6'd0, enable_value});
        while (items_sent < target) send_random_transfer();
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= EV_ADDRESS;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_DEVICE_ADDRESS;
        i_cfg_data    <= '0;
        items_sent    = 0;
        mismatches    = 0;
        idle_off      = 1'b0;
        hold_request  = 1'b0;
        p_expect_ctrl = 1'b1;
        p_data_mode   = 1'b0;
        p_cmd         = 8'h00;
        p_args        = 2'd0;
        p_col         = 8'd0;
        p_page        = 3'd0;
        p_amode       = 2'd0;
        p_bright      = 8'd255;
        p_disp        = 1'b0;
        cfg_addr      = 7'd60;
        cfg_enable    = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_address_decode();
        test_commands();
        test_data_edges();
        test_backpressure();
        test_random_phase(500, 7'd60, 1'b1);
        test_random_phase(800, 7'd127, 1'b1);
        test_random_phase(950, 7'd0, 1'b0);
        test_random_phase(1300, 7'($urandom_range(0, 127)), 1'b1);
        idle_off = 1'b1;
        test_random_phase(1650, 7'd60, 1'b1);

        // drain
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ocp_pkg.sv
sv/oled_controller_command_parser.sv
tb/sv/tb.sv
